// ----- design/sarf_pkg.sv -----
// Shared types and constants for the sorted address range filter.
`default_nettype none
package sarf_pkg;

	localparam int MAX_RANGES = 8;
	localparam int ADDR_W     = 48;
	localparam int IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
	localparam int CNT_W      = $clog2(MAX_RANGES + 1);
	localparam int COUNT_W    = 4;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_CLEAR  = 2'd1;
	localparam logic [1:0] MODE_LOOKUP = 2'd2;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_FULL      = 2'd1;
	localparam logic [1:0] STATUS_BAD_RANGE = 2'd2;

	typedef struct packed {
		logic [1:0]        mode;
		logic [ADDR_W-1:0] range_start;
		logic [ADDR_W-1:0] range_end;
		logic [ADDR_W-1:0] query_address;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic               filtered_out;
		logic [COUNT_W-1:0] entry_count;
	} result_t;

	typedef struct packed {
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
	} entry_t;

	typedef struct packed {
		logic             we;
		logic [IDX_W-1:0] waddr;
		entry_t           wdata;
		logic             re;
		logic [IDX_W-1:0] raddr;
	} mem_req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_PLACE,
		S_DONE
	} state_t;

endpackage
`default_nettype wire

// ----- design/sarf_if.sv -----
// Valid/ready channel interfaces for items and results.
`default_nettype none
interface sarf_item_if import sarf_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sarf_result_if import sarf_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- design/sorted_address_range_filter.sv -----
// Top level of the sorted address range filter: sequencer plus range table RAM.
//
//   channel  dir  handshake       payload
//   item     in   valid / ready   mode, range_start, range_end, query_address
//   result   out  valid / ready   status, filtered_out, entry_count
//
// One item at a time. Clear, full, bad range, empty-table and unused-mode items
// go from acceptance through S_DONE into the result register. A lookup first walks n
// entries in S_SCAN (one RAM read per cycle, n <= 8). An insert into a filled table
// shifts n entries down one slot in S_SCAN, then the new range is written (S_SCAN or S_PLACE).
// The table RAM holds no reset; only the count and control are cleared by arst_n.
// A waiting result holds in the output register; the next item is taken meanwhile.
`default_nettype none
module sorted_address_range_filter import sarf_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	sarf_item_if.sink     item,
	sarf_result_if.source result
);

	mem_req_t mem_req;
	entry_t   rd_data;

	sarf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.result  (result),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	sarf_ram #(
		.DATA_W ($bits(entry_t)),
		.DEPTH  (MAX_RANGES),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (rd_data)
	);

`ifndef ASSERT_OFF
	// A shift never reads the slot it writes in the same cycle, so no forwarding.
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
		else $error("RAM read and write hit the same entry");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.data.entry_count <= COUNT_W'(MAX_RANGES)))
		else $error("entry count beyond table depth");

	a_fail_passes: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.data.status != STATUS_OK)) |-> !result.data.filtered_out)
		else $error("failed insert reported a filter decision");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=> !item.ready)
		else $error("second transaction taken while one is in progress");
`endif

endmodule
`default_nettype wire

// ----- design/sarf_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module sarf_ram #(
	parameter int DATA_W = 96,
	parameter int DEPTH  = 8,
	parameter int ADDR_W = 3
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output      logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ----- design/sarf_ctrl.sv -----
// Sequencer: walks the range table in memory for lookups and shifting inserts.
`default_nettype none
module sarf_ctrl import sarf_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	sarf_item_if.sink   item,
	sarf_result_if.source result,
	output mem_req_t    mem_req,
	input  wire entry_t rd_data
);

	state_t            state_q, state_d;
	logic [IDX_W-1:0]  k_q;
	logic [CNT_W-1:0]  cnt_q;
	item_t             op_q;
	result_t           pend_q;
	result_t           res_q;
	logic              res_valid_q;

	logic              accept;
	logic              is_full;
	logic              bad_range;
	logic              needs_scan;
	logic              look_below;
	logic              look_in;
	logic              look_last;
	logic              look_end;
	logic              ins_shift;
	logic              k_zero;
	logic              fin;
	result_t           fin_res;
	logic [CNT_W-1:0]  cnt_next;
	logic              load_out;
	entry_t            new_entry;

	assign accept     = item.valid && item.ready;
	assign is_full    = cnt_q >= CNT_W'(MAX_RANGES);
	assign bad_range  = item.data.range_end < item.data.range_start;
	assign needs_scan = (cnt_q != '0) &&
		((item.data.mode == MODE_LOOKUP) ||
		 ((item.data.mode == MODE_INSERT) && !is_full && !bad_range));

	assign look_below = op_q.query_address < rd_data.lo;
	assign look_in    = op_q.query_address <= rd_data.hi;
	assign look_last  = (CNT_W'({1'b0, k_q}) + CNT_W'(1)) == cnt_q;
	assign look_end   = look_below || look_in || look_last;
	assign ins_shift  = op_q.range_start < rd_data.lo;
	assign k_zero     = k_q == '0;
	assign new_entry  = '{lo: op_q.range_start, hi: op_q.range_end};

	// Result and count for the item that finishes this cycle
	always_comb begin
		fin      = 1'b0;
		fin_res  = '{status: STATUS_OK, filtered_out: 1'b0, entry_count: COUNT_W'(cnt_q)};
		cnt_next = cnt_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !needs_scan) begin
					fin = 1'b1;
					priority case (item.data.mode)
						MODE_INSERT: begin
							if (is_full) begin
								fin_res.status = STATUS_FULL;
							end else if (bad_range) begin
								fin_res.status = STATUS_BAD_RANGE;
							end else begin
								cnt_next = CNT_W'(1);
							end
						end
						MODE_CLEAR: begin
							cnt_next = '0;
						end
						default: begin
						end
					endcase
				end
			end
			S_SCAN: begin
				if (op_q.mode == MODE_LOOKUP) begin
					if (look_end) begin
						fin = 1'b1;
						fin_res.filtered_out = look_below || !look_in;
					end
				end else if (!ins_shift) begin
					fin      = 1'b1;
					cnt_next = cnt_q + CNT_W'(1);
				end
			end
			S_PLACE: begin
				fin      = 1'b1;
				cnt_next = cnt_q + CNT_W'(1);
			end
			S_DONE: begin
			end
		endcase
		fin_res.entry_count = COUNT_W'(cnt_next);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = needs_scan ? S_SCAN : S_DONE;
				end
			end
			S_SCAN: begin
				if (op_q.mode == MODE_LOOKUP) begin
					if (look_end) begin
						state_d = S_DONE;
					end
				end else if (!ins_shift) begin
					state_d = S_DONE;
				end else if (k_zero) begin
					state_d = S_PLACE;
				end
			end
			S_PLACE: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (load_out) begin
					state_d = S_IDLE;
				end
			end
		endcase
	end

	// Outputs: memory requests and handshakes
	always_comb begin
		mem_req  = '0;
		load_out = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mem_req.re    = accept && needs_scan;
				mem_req.raddr = (item.data.mode == MODE_LOOKUP) ? '0 :
					IDX_W'(cnt_q - CNT_W'(1));
				// insert into an empty table goes straight to slot zero
				mem_req.we    = accept && (item.data.mode == MODE_INSERT) &&
					(cnt_q == '0) && !bad_range;
				mem_req.waddr = '0;
				mem_req.wdata = '{lo: item.data.range_start, hi: item.data.range_end};
			end
			S_SCAN: begin
				if (op_q.mode == MODE_LOOKUP) begin
					mem_req.re    = !look_end;
					mem_req.raddr = k_q + IDX_W'(1);
				end else begin
					// move the entry down one slot, or drop the new range in behind it
					mem_req.we    = 1'b1;
					mem_req.waddr = k_q + IDX_W'(1);
					mem_req.wdata = ins_shift ? rd_data : new_entry;
					mem_req.re    = ins_shift && !k_zero;
					mem_req.raddr = k_q - IDX_W'(1);
				end
			end
			S_PLACE: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = new_entry;
			end
			S_DONE: begin
				load_out = !res_valid_q || result.ready;
			end
		endcase
	end

	assign item.ready   = state_q == S_IDLE;
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				cnt_q <= cnt_next;
			end
			if (load_out) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= item.data;
			k_q  <= (item.data.mode == MODE_LOOKUP) ? '0 : IDX_W'(cnt_q - CNT_W'(1));
		end else if (state_q == S_SCAN) begin
			k_q <= (op_q.mode == MODE_LOOKUP) ? k_q + IDX_W'(1) : k_q - IDX_W'(1);
		end
		if (fin) begin
			pend_q <= fin_res;
		end
		if (load_out) begin
			res_q <= pend_q;
		end
	end

endmodule
`default_nettype wire

// ----- dv/sarf_result_checker.sv -----
// Checker for the sorted address range filter: shadow range table, expected results, compare.
`timescale 1ns / 100ps
module sarf_result_checker import sarf_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	sarf_item_if       item,
	sarf_result_if     result,
	output int unsigned error_count,
	output int unsigned pending
);

	logic [ADDR_W-1:0] range_lo [MAX_RANGES];
	logic [ADDR_W-1:0] range_hi [MAX_RANGES];
	int unsigned       range_count;
	result_t           predicted_results [$];
	result_t           oldest;

	// Applies one item to the shadow table and returns the result it should produce.
	function automatic result_t apply_to_table(input item_t it);
		result_t     r;
		int unsigned slot;
		int          k;
		r = '0;
		case (it.mode)
			MODE_INSERT: begin
				if (range_count == MAX_RANGES) begin
					r.status = STATUS_FULL;
				end else if (it.range_end < it.range_start) begin
					r.status = STATUS_BAD_RANGE;
				end else begin
					// equal starts go behind the ones already stored
					slot = range_count;
					for (k = 0; k < range_count; k++) begin
						if (it.range_start < range_lo[k]) begin
							slot = k;
							break;
						end
					end
					for (k = range_count; k > slot; k--) begin
						range_lo[k] = range_lo[k-1];
						range_hi[k] = range_hi[k-1];
					end
					range_lo[slot] = it.range_start;
					range_hi[slot] = it.range_end;
					range_count++;
				end
			end
			MODE_CLEAR: begin
				range_count = 0;
			end
			MODE_LOOKUP: begin
				if (range_count != 0) begin
					r.filtered_out = 1'b1;
					for (k = 0; k < range_count; k++) begin
						if (it.query_address < range_lo[k])
							break;
						if (it.query_address <= range_hi[k]) begin
							r.filtered_out = 1'b0;
							break;
						end
					end
				end
			end
			default: begin
			end
		endcase
		r.entry_count = range_count[COUNT_W-1:0];
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		error_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_count = 0;
			predicted_results.delete();
			error_count = 0;
			pending <= 0;
		end else begin
			// result first: an item taken at this edge cannot have its result yet
			if (result.valid && result.ready) begin
				if (predicted_results.size() == 0) begin
					report_mismatch("result transaction with nothing expected");
				end else begin
					oldest = predicted_results.pop_front();
					if (result.data.status !== oldest.status)
						report_mismatch($sformatf("status: expected %0d got %0d",
							oldest.status, result.data.status));
					if (result.data.filtered_out !== oldest.filtered_out)
						report_mismatch($sformatf("filtered_out: expected %0d got %0d",
							oldest.filtered_out, result.data.filtered_out));
					if (result.data.entry_count !== oldest.entry_count)
						report_mismatch($sformatf("entry_count: expected %0d got %0d",
							oldest.entry_count, result.data.entry_count));
				end
			end
			if (item.valid && item.ready)
				predicted_results.push_back(apply_to_table(item.data));
			pending <= predicted_results.size();
		end
	end

endmodule

// ----- dv/sorted_address_range_filter_test.sv -----
// Top of the sorted address range filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module sorted_address_range_filter_test;
	import sarf_pkg::*;

	localparam logic [1:0]        MODE_UNUSED   = 2'd3;
	localparam logic [ADDR_W-1:0] ADDR_MAX      = '1;
	localparam int                PHASE_ITEMS   = 500;
	localparam int                STALL_LIMIT   = 5000;
	localparam int                SETTLE_CYCLES = 20;

	logic        clk;
	logic        arst_n;
	int unsigned error_count;
	int unsigned pending;
	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned sent_in_phase      = 0;
	int unsigned quiet_cycles       = 0;

	sarf_item_if   item_ch ();
	sarf_result_if result_ch ();

	sorted_address_range_filter i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	sarf_result_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.error_count (error_count),
		.pending     (pending)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	always @(posedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// watchdog: too long without any transaction on either channel
	always @(posedge clk) begin
		if (!arst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
			$display("[sorted_address_range_filter] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[ADDR_W-1:0];
	endfunction

	function automatic item_t make_item(input logic [1:0] mode, input logic [ADDR_W-1:0] lo,
			input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] addr);
		item_t it;
		it.mode          = mode;
		it.range_start   = lo;
		it.range_end     = hi;
		it.query_address = addr;
		return it;
	endfunction

	// valid is left high after the transaction; the next call lowers it only for a gap
	task automatic send_item(input item_t it);
		while ($urandom_range(99) < sender_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.data  <= it;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		sent_in_phase++;
	endtask

	task automatic wait_for_drain();
		item_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (pending != 0);
	endtask

	// An optional clear, a burst of inserts and lookups mostly inside one 64-address window, so that
	// overlaps, equal starts, hits, misses and a full table come up often.
	task automatic run_sequence();
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] lo;
		logic [ADDR_W-1:0] hi;
		int                n;
		int                i;
		case ($urandom_range(5))
			0: base = '0;
			1: base = {ADDR_MAX[ADDR_W-1:6], 6'b0};
			default: begin
				base      = rand_addr();
				base[5:0] = '0;
			end
		endcase
		if ($urandom_range(3) != 0)
			send_item(make_item(MODE_CLEAR, rand_addr(), rand_addr(), rand_addr()));
		n = $urandom_range(1, 10);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(99) < 15) begin
				lo = base + $urandom_range(8, 63);
				hi = lo - $urandom_range(1, 8);
			end else begin
				lo = base + $urandom_range(0, 56);
				hi = lo + $urandom_range(0, 7);
			end
			send_item(make_item(MODE_INSERT, lo, hi, rand_addr()));
			if ($urandom_range(3) == 0)
				send_item(make_item(MODE_LOOKUP, rand_addr(), rand_addr(),
					base + $urandom_range(0, 63)));
		end
		n = $urandom_range(3, 12);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(9) == 0)
				send_item(make_item(MODE_LOOKUP, rand_addr(), rand_addr(), rand_addr()));
			else
				send_item(make_item(MODE_LOOKUP, rand_addr(), rand_addr(),
					base + $urandom_range(0, 63)));
		end
		if ($urandom_range(99) < 15)
			send_item(make_item(2'($urandom_range(3)), rand_addr(), rand_addr(), rand_addr()));
	endtask

	initial begin
		int unsigned sender_pct [4];
		int unsigned receiver_pct [4];
		int          p;
		sender_pct   = '{0, 58, 0, 11};
		receiver_pct = '{0, 0, 58, 11};

		arst_n          <= 1'b0;
		item_ch.valid   <= 1'b0;
		item_ch.data    <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, extremes, equal starts, bad ranges, full table, clear
		send_item(make_item(MODE_LOOKUP, '0, '0, ADDR_MAX));
		send_item(make_item(MODE_INSERT, 48'd100, 48'd200, '0));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd50));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd300));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd150));
		send_item(make_item(MODE_INSERT, '0, '0, '0));
		send_item(make_item(MODE_INSERT, ADDR_MAX, ADDR_MAX, '0));
		send_item(make_item(MODE_INSERT, 48'd100, 48'd100, '0));
		send_item(make_item(MODE_INSERT, 48'd5, 48'd4, '0));
		send_item(make_item(MODE_INSERT, '0, ADDR_MAX, '0));
		send_item(make_item(MODE_LOOKUP, '0, '0, '0));
		send_item(make_item(MODE_LOOKUP, '0, '0, ADDR_MAX));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd201));
		send_item(make_item(MODE_UNUSED, ADDR_MAX, ADDR_MAX, ADDR_MAX));
		send_item(make_item(MODE_INSERT, 48'd50, 48'd60, '0));
		send_item(make_item(MODE_INSERT, 48'd10, 48'd20, '0));
		send_item(make_item(MODE_INSERT, 48'd30, 48'd40, '0));
		// full takes precedence over a bad range
		send_item(make_item(MODE_INSERT, 48'd1, 48'd0, '0));
		send_item(make_item(MODE_INSERT, 48'd1, 48'd2, '0));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd201));
		send_item(make_item(MODE_CLEAR, '0, '0, '0));
		send_item(make_item(MODE_LOOKUP, '0, '0, 48'd5));
		send_item(make_item(MODE_UNUSED, '0, '0, '0));
		send_item(make_item(MODE_INSERT, ADDR_MAX, '0, '0));
		wait_for_drain();

		for (p = 0; p < 4; p++) begin
			sender_idle_pct    = sender_pct[p];
			receiver_stall_pct = receiver_pct[p];
			sent_in_phase      = 0;
			while (sent_in_phase < PHASE_ITEMS)
				run_sequence();
			wait_for_drain();
		end

		receiver_stall_pct = 0;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("[sorted_address_range_filter] OK");
		else
			$display("[sorted_address_range_filter] ERROR");
		$finish;
	end

endmodule
